// ----- rtl/apt_pkg.sv -----
// Shared types, constants and register indexes for the arm pointing table locator.
// No dependencies.
package apt_pkg;

	localparam int COORD_W = 16;
	localparam int OPND_W  = 18;
	localparam int PROD_W  = 2 * OPND_W;
	localparam int QUO_W   = 18;
	localparam int DIV_W   = 18;
	localparam int NUM_W   = 33;

	localparam logic [2:0] REG_X_ORIGIN   = 3'd0;
	localparam logic [2:0] REG_Y_ORIGIN   = 3'd1;
	localparam logic [2:0] REG_WIDTH      = 3'd2;
	localparam logic [2:0] REG_HEIGHT     = 3'd3;
	localparam logic [2:0] REG_WORKING    = 3'd4;
	localparam logic [2:0] REG_READY_LOW  = 3'd5;
	localparam logic [2:0] REG_READY_HIGH = 3'd6;
	localparam logic [2:0] REG_AWAY       = 3'd7;

	localparam logic [15:0] RST_WORKING    = 16'd300;
	localparam logic [15:0] RST_READY_LOW  = 16'd500;
	localparam logic [15:0] RST_READY_HIGH = 16'd1000;
	localparam logic [15:0] RST_AWAY       = 16'd1200;

	localparam logic [1:0] ACT_UNKNOWN = 2'd0;
	localparam logic [1:0] ACT_WORKING = 2'd1;
	localparam logic [1:0] ACT_READY   = 2'd2;
	localparam logic [1:0] ACT_AWAY    = 2'd3;

	localparam logic [2:0] IDX_EX = 3'd0;
	localparam logic [2:0] IDX_EY = 3'd1;
	localparam logic [2:0] IDX_EZ = 3'd2;
	localparam logic [2:0] IDX_HX = 3'd3;
	localparam logic [2:0] IDX_HY = 3'd4;
	localparam logic [2:0] IDX_HZ = 3'd5;

	localparam logic [3:0] OP_EX_HZ     = 4'd0;
	localparam logic [3:0] OP_HX_EZ     = 4'd1;
	localparam logic [3:0] OP_EY_HZ     = 4'd2;
	localparam logic [3:0] OP_HY_EZ     = 4'd3;
	localparam logic [3:0] OP_XLO       = 4'd4;
	localparam logic [3:0] OP_XHI       = 4'd5;
	localparam logic [3:0] OP_YLO       = 4'd6;
	localparam logic [3:0] OP_YHI       = 4'd7;
	localparam logic [3:0] OP_DX        = 4'd8;
	localparam logic [3:0] OP_DY        = 4'd9;
	localparam logic [3:0] OP_DZ        = 4'd10;
	localparam logic [3:0] OP_LIM_WORK  = 4'd11;
	localparam logic [3:0] OP_LIM_RLOW  = 4'd12;
	localparam logic [3:0] OP_LIM_RHIGH = 4'd13;
	localparam logic [3:0] OP_LIM_AWAY  = 4'd14;

	typedef struct packed {
		logic             done;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} apt_div_res_t;

endpackage

// ----- rtl/apt_if.sv -----
// Valid/ready channel interfaces for skeleton samples and locator results.
// Depends on nothing.
interface apt_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] arm_a_elbow_x;
	logic signed [15:0] arm_a_elbow_y;
	logic signed [15:0] arm_a_elbow_z;
	logic signed [15:0] arm_a_hand_x;
	logic signed [15:0] arm_a_hand_y;
	logic signed [15:0] arm_a_hand_z;
	logic signed [15:0] arm_b_elbow_x;
	logic signed [15:0] arm_b_elbow_y;
	logic signed [15:0] arm_b_elbow_z;
	logic signed [15:0] arm_b_hand_x;
	logic signed [15:0] arm_b_hand_y;
	logic signed [15:0] arm_b_hand_z;

	modport source (output valid, arm_a_elbow_x, arm_a_elbow_y, arm_a_elbow_z, arm_a_hand_x,
		arm_a_hand_y, arm_a_hand_z, arm_b_elbow_x, arm_b_elbow_y, arm_b_elbow_z, arm_b_hand_x,
		arm_b_hand_y, arm_b_hand_z, input ready);
	modport sink (input valid, arm_a_elbow_x, arm_a_elbow_y, arm_a_elbow_z, arm_a_hand_x,
		arm_a_hand_y, arm_a_hand_z, arm_b_elbow_x, arm_b_elbow_y, arm_b_elbow_z, arm_b_hand_x,
		arm_b_hand_y, arm_b_hand_z, output ready);
endinterface

interface apt_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] arm_a_hit_x;
	logic signed [15:0] arm_a_hit_y;
	logic               arm_a_pointing;
	logic signed [15:0] arm_b_hit_x;
	logic signed [15:0] arm_b_hit_y;
	logic               arm_b_pointing;
	logic [1:0]         activity_level;
	logic               activity_changed;

	modport source (output valid, arm_a_hit_x, arm_a_hit_y, arm_a_pointing, arm_b_hit_x,
		arm_b_hit_y, arm_b_pointing, activity_level, activity_changed, input ready);
	modport sink (input valid, arm_a_hit_x, arm_a_hit_y, arm_a_pointing, arm_b_hit_x,
		arm_b_hit_y, arm_b_pointing, activity_level, activity_changed, output ready);
endinterface

// ----- rtl/arm_pointing_table_locator.sv -----
// Top level of the arm pointing table locator: sequencer, shared multiplier and result register.
// Depends on apt_pkg, apt_in_if, apt_out_if and apt_div.
// One sample is taken at a time and yields one result word. Each arm runs eleven multiply
// steps on one shared 18 by 18 multiplier, then two bit-serial divisions; four more
// multiply steps square the activity limits. A new sample is accepted once the previous
// result has been loaded into the output register, so a stalled result side also holds
// off new samples.
module arm_pointing_table_locator import apt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	apt_in_if.sink      sample,
	apt_out_if.source   result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIVS = 3'd2;
	localparam logic [2:0] ST_DIVW = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] st_q;
	logic [3:0] op_q;
	logic       ph_q;
	logic       arm_q;
	logic       dsel_q;

	logic signed [15:0] xo_q, yo_q;
	logic [14:0]        w_q, h_q;
	logic [15:0]        lw_q, lrl_q, lrh_q, la_q;
	logic [1:0]         act_q;

	logic signed [COORD_W-1:0] crd_q [2][6];
	logic signed [PROD_W-1:0]  prod_s1;
	logic signed [PROD_W-1:0]  acc_q, nx_q, ny_q;
	logic [PROD_W-1:0]         dist_q, dist_a_q, dmin_q;
	logic                      in_ok_q;
	logic                      f_work_q, f_rl_q, f_rh_q, f_aw_q;
	logic signed [15:0]        hitx_q [2];
	logic signed [15:0]        hity_q [2];
	logic                      pnt_q [2];

	logic                 res_valid_q;
	logic signed [15:0]   o_ax_q, o_ay_q, o_bx_q, o_by_q;
	logic                 o_ap_q, o_bp_q, o_chg_q;
	logic [1:0]           o_lvl_q;

	logic signed [15:0] ex, ey, ez, hx, hy, hz;
	logic signed [16:0] den_x;
	logic               neg, den_zero;
	logic [OPND_W-1:0]  den_abs;
	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [OPND_W-1:0] xo_ext, yo_ext, xw, yh, dx, dy, dz;
	logic signed [PROD_W-1:0] sel, sel_abs;
	logic [NUM_W-1:0]   div_num;
	logic [DIV_W-1:0]   div_den;
	logic [PROD_W-1:0]  lim4;
	logic [15:0]        hitv;
	logic [1:0]         nxt;
	logic               fin_go;
	apt_div_res_t       dres;

	function automatic logic [15:0] sat_hit(input logic qneg, input logic ovf,
		input logic [QUO_W-1:0] q);
		logic [QUO_W-1:0] nq;
		begin
			nq = ~q + 1'b1;
			if (!qneg) begin
				sat_hit = (ovf || q > QUO_W'(32767)) ? 16'h7FFF : q[15:0];
			end else begin
				sat_hit = (ovf || q > QUO_W'(32768)) ? 16'h8000 : nq[15:0];
			end
		end
	endfunction

	assign ex = crd_q[arm_q][IDX_EX];
	assign ey = crd_q[arm_q][IDX_EY];
	assign ez = crd_q[arm_q][IDX_EZ];
	assign hx = crd_q[arm_q][IDX_HX];
	assign hy = crd_q[arm_q][IDX_HY];
	assign hz = crd_q[arm_q][IDX_HZ];

	assign den_x    = {hz[15], hz} - {ez[15], ez};
	assign neg      = den_x[16];
	assign den_zero = (den_x == 17'sd0);
	assign den_abs  = neg ? (OPND_W'(0) - {den_x[16], den_x}) : {den_x[16], den_x};

	assign xo_ext = {{2{xo_q[15]}}, xo_q};
	assign yo_ext = {{2{yo_q[15]}}, yo_q};
	assign xw     = xo_ext + $signed({3'b000, w_q});
	assign yh     = yo_ext + $signed({3'b000, h_q});
	assign dx     = $signed({hx[15], hx, 1'b0}) + $signed({3'b000, w_q});
	assign dy     = $signed({hy[15], hy, 1'b0}) + $signed({3'b000, h_q});
	assign dz     = $signed({hz[15], hz, 1'b0});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_EX_HZ:     begin mul_a = OPND_W'(ex); mul_b = OPND_W'(hz); end
			OP_HX_EZ:     begin mul_a = OPND_W'(hx); mul_b = OPND_W'(ez); end
			OP_EY_HZ:     begin mul_a = OPND_W'(ey); mul_b = OPND_W'(hz); end
			OP_HY_EZ:     begin mul_a = OPND_W'(hy); mul_b = OPND_W'(ez); end
			OP_XLO:       begin mul_a = xo_ext; mul_b = $signed(den_abs); end
			OP_XHI:       begin mul_a = xw;     mul_b = $signed(den_abs); end
			OP_YLO:       begin mul_a = yo_ext; mul_b = $signed(den_abs); end
			OP_YHI:       begin mul_a = yh;     mul_b = $signed(den_abs); end
			OP_DX:        begin mul_a = dx; mul_b = dx; end
			OP_DY:        begin mul_a = dy; mul_b = dy; end
			OP_DZ:        begin mul_a = dz; mul_b = dz; end
			OP_LIM_WORK:  begin mul_a = $signed({2'b00, lw_q});  mul_b = $signed({2'b00, lw_q}); end
			OP_LIM_RLOW:  begin mul_a = $signed({2'b00, lrl_q}); mul_b = $signed({2'b00, lrl_q}); end
			OP_LIM_RHIGH: begin mul_a = $signed({2'b00, lrh_q}); mul_b = $signed({2'b00, lrh_q}); end
			OP_LIM_AWAY:  begin mul_a = $signed({2'b00, la_q});  mul_b = $signed({2'b00, la_q}); end
			default:      begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign sel     = dsel_q ? ny_q : nx_q;
	assign sel_abs = sel[PROD_W-1] ? -sel : sel;
	assign div_num = {sel_abs[31:0], 1'b0} + NUM_W'(den_abs);
	assign div_den = {den_abs[16:0], 1'b0};
	assign lim4    = {prod_s1[PROD_W-3:0], 2'b00};
	assign hitv    = den_zero ? 16'h0000 : sat_hit(sel[PROD_W-1], dres.ovf, dres.quo);

	apt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (st_q == ST_DIVS),
		.num    (div_num),
		.den    (div_den),
		.res    (dres)
	);

	always_comb begin
		if (f_work_q) begin
			nxt = ACT_WORKING;
		end else if (f_rl_q && f_rh_q) begin
			nxt = ACT_READY;
		end else if (f_aw_q) begin
			nxt = ACT_AWAY;
		end else begin
			nxt = act_q;
		end
	end

	assign fin_go       = (st_q == ST_FIN) && (!res_valid_q || result.ready);
	assign sample.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xo_q  <= '0;
			yo_q  <= '0;
			w_q   <= '0;
			h_q   <= '0;
			lw_q  <= RST_WORKING;
			lrl_q <= RST_READY_LOW;
			lrh_q <= RST_READY_HIGH;
			la_q  <= RST_AWAY;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_ORIGIN:   xo_q  <= cfg_wdata;
				REG_Y_ORIGIN:   yo_q  <= cfg_wdata;
				REG_WIDTH:      w_q   <= cfg_wdata[14:0];
				REG_HEIGHT:     h_q   <= cfg_wdata[14:0];
				REG_WORKING:    lw_q  <= cfg_wdata;
				REG_READY_LOW:  lrl_q <= cfg_wdata;
				REG_READY_HIGH: lrh_q <= cfg_wdata;
				REG_AWAY:       la_q  <= cfg_wdata;
				default:        xo_q  <= xo_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			op_q        <= OP_EX_HZ;
			ph_q        <= 1'b0;
			arm_q       <= 1'b0;
			dsel_q      <= 1'b0;
			act_q       <= ACT_UNKNOWN;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (sample.valid) begin
						st_q   <= ST_MUL;
						op_q   <= OP_EX_HZ;
						ph_q   <= 1'b0;
						arm_q  <= 1'b0;
						dsel_q <= 1'b0;
					end
				end
				ST_MUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (op_q == OP_DZ) begin
							st_q <= ST_DIVS;
						end else if (op_q == OP_LIM_AWAY) begin
							st_q <= ST_FIN;
						end else begin
							op_q <= op_q + 1'b1;
						end
					end
				end
				ST_DIVS: begin
					st_q <= ST_DIVW;
				end
				ST_DIVW: begin
					if (dres.done) begin
						if (!dsel_q) begin
							dsel_q <= 1'b1;
							st_q   <= ST_DIVS;
						end else begin
							dsel_q <= 1'b0;
							ph_q   <= 1'b0;
							st_q   <= ST_MUL;
							if (!arm_q) begin
								arm_q <= 1'b1;
								op_q  <= OP_EX_HZ;
							end else begin
								op_q <= OP_LIM_WORK;
							end
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						act_q       <= nxt;
						res_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			crd_q[0][IDX_EX] <= sample.arm_a_elbow_x;
			crd_q[0][IDX_EY] <= sample.arm_a_elbow_y;
			crd_q[0][IDX_EZ] <= sample.arm_a_elbow_z;
			crd_q[0][IDX_HX] <= sample.arm_a_hand_x;
			crd_q[0][IDX_HY] <= sample.arm_a_hand_y;
			crd_q[0][IDX_HZ] <= sample.arm_a_hand_z;
			crd_q[1][IDX_EX] <= sample.arm_b_elbow_x;
			crd_q[1][IDX_EY] <= sample.arm_b_elbow_y;
			crd_q[1][IDX_EZ] <= sample.arm_b_elbow_z;
			crd_q[1][IDX_HX] <= sample.arm_b_hand_x;
			crd_q[1][IDX_HY] <= sample.arm_b_hand_y;
			crd_q[1][IDX_HZ] <= sample.arm_b_hand_z;
		end
		if (st_q == ST_MUL && ph_q) begin
			case (op_q)
				OP_EX_HZ:     acc_q    <= prod_s1;
				OP_HX_EZ:     nx_q     <= neg ? (prod_s1 - acc_q) : (acc_q - prod_s1);
				OP_EY_HZ:     acc_q    <= prod_s1;
				OP_HY_EZ:     ny_q     <= neg ? (prod_s1 - acc_q) : (acc_q - prod_s1);
				OP_XLO:       in_ok_q  <= (nx_q >= prod_s1);
				OP_XHI:       in_ok_q  <= in_ok_q && (nx_q <= prod_s1);
				OP_YLO:       in_ok_q  <= in_ok_q && (ny_q >= prod_s1);
				OP_YHI:       in_ok_q  <= in_ok_q && (ny_q <= prod_s1);
				OP_DX:        dist_q   <= PROD_W'(prod_s1);
				OP_DY:        dist_q   <= dist_q + PROD_W'(prod_s1);
				OP_DZ:        dist_q   <= dist_q + PROD_W'(prod_s1);
				OP_LIM_WORK:  f_work_q <= (dmin_q < lim4);
				OP_LIM_RLOW:  f_rl_q   <= (dmin_q > lim4);
				OP_LIM_RHIGH: f_rh_q   <= (dmin_q < lim4);
				OP_LIM_AWAY:  f_aw_q   <= (dmin_q > lim4);
				default:      acc_q    <= acc_q;
			endcase
		end
		if (st_q == ST_DIVW && dres.done) begin
			if (!dsel_q) begin
				hitx_q[arm_q] <= hitv;
			end else begin
				hity_q[arm_q] <= hitv;
				pnt_q[arm_q]  <= neg && in_ok_q;
				if (!arm_q) begin
					dist_a_q <= dist_q;
				end else begin
					dmin_q <= (dist_a_q < dist_q) ? dist_a_q : dist_q;
				end
			end
		end
		if (fin_go) begin
			o_ax_q  <= hitx_q[0];
			o_ay_q  <= hity_q[0];
			o_ap_q  <= pnt_q[0];
			o_bx_q  <= hitx_q[1];
			o_by_q  <= hity_q[1];
			o_bp_q  <= pnt_q[1];
			o_lvl_q <= nxt;
			o_chg_q <= (nxt != act_q);
		end
	end

	assign result.valid            = res_valid_q;
	assign result.arm_a_hit_x      = o_ax_q;
	assign result.arm_a_hit_y      = o_ay_q;
	assign result.arm_a_pointing   = o_ap_q;
	assign result.arm_b_hit_x      = o_bx_q;
	assign result.arm_b_hit_y      = o_by_q;
	assign result.arm_b_pointing   = o_bp_q;
	assign result.activity_level   = o_lvl_q;
	assign result.activity_changed = o_chg_q;

	a_chg_known: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.activity_changed |-> result.activity_level != ACT_UNKNOWN)
		else $error("activity change reported toward unknown level");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		dres.done |-> st_q == ST_DIVW)
		else $error("divider finished outside of its wait state");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> st_q == ST_MUL && op_q == OP_EX_HZ && !arm_q)
		else $error("sequencer did not start on an accepted sample");

endmodule

// ----- rtl/apt_div.sv -----
// Bit-serial restoring divider producing one quotient bit per cycle with overflow detect.
// Depends on apt_pkg.
module apt_div import apt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   num,
	input  logic [DIV_W-1:0]   den,
	output apt_div_res_t       res
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic             ovf_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [QUO_W-1:0] sh_q;
	logic [DIV_W-1:0] d_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic [DIV_W-1:0] num_hi;

	assign num_hi = DIV_W'(num[NUM_W-1:QUO_W]);
	assign trial  = {rem_q, sh_q[QUO_W-1]};
	assign diff   = trial - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= (num_hi >= den);
			rem_q <= num_hi;
			sh_q  <= num[QUO_W-1:0];
			d_q   <= den;
		end else if (busy_q) begin
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				sh_q  <= {sh_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				sh_q  <= {sh_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign res = '{done: done_q, ovf: ovf_q, quo: sh_q};

endmodule
